// File: sv/arpc_pkg.sv
// arpc_pkg: commands, table word and engine control types for the arp cache
`timescale 1ns / 1ps
package arpc_pkg;

  typedef logic [1:0] cmd_t;

  localparam cmd_t CMD_LOOKUP = 2'd0;
  localparam cmd_t CMD_INSERT = 2'd1;
  localparam cmd_t CMD_TICK   = 2'd2;

  localparam int SLOT_W  = 7;
  localparam int COUNT_W = 8;
  localparam int TMO_W   = 15;
  localparam int SEC_W   = 16;

  localparam logic [TMO_W-1:0] TIMEOUT_RESET = 15'd15;

  // one table word as stored in memory
  typedef struct packed {
    logic             valid;
    logic [31:0]      ip;
    logic [47:0]      mac;
    logic [SEC_W-1:0] stamp;
  } entry_t;

  typedef struct packed {
    cmd_t             cmd;
    logic [31:0]      ip;
    logic [47:0]      mac;
    logic [SEC_W-1:0] now;
    logic [TMO_W-1:0] timeout;
  } job_t;

  typedef struct packed {
    logic               found;
    logic [47:0]        mac;
    logic [SLOT_W-1:0]  slot;
    logic [COUNT_W-1:0] expired;
  } res_t;

  typedef struct packed {
    logic start;
    logic take;
    job_t job;
  } eng_ctl_t;

  typedef struct packed {
    logic ready;
    logic done;
    res_t res;
  } eng_stat_t;

endpackage

// File: sv/arpc_if.sv
// arpc_if: request, response and configuration channel interfaces
`timescale 1ns / 1ps
interface arpc_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [31:0] ip_addr;
  logic [47:0] mac_addr;
  modport source (output valid, command, ip_addr, mac_addr, input ready);
  modport sink (input valid, command, ip_addr, mac_addr, output ready);
endinterface

interface arpc_rsp_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [47:0] mac_out;
  logic [6:0]  slot;
  logic [7:0]  expired_count;
  modport source (output valid, found, mac_out, slot, expired_count, input ready);
  modport sink (input valid, found, mac_out, slot, expired_count, output ready);
endinterface

interface arpc_cfg_if;
  logic        valid;
  logic        ready;
  logic [14:0] entry_timeout;
  modport source (output valid, entry_timeout, input ready);
  modport sink (input valid, entry_timeout, output ready);
endinterface

// File: sv/arp_cache_with_aging_unit.sv
// arp_cache_with_aging_unit: arp cache top level with config, clock of seconds and result register
//
//   channel  role    transfer          payload
//   req      sink    valid & ready     command, ip_addr, mac_addr
//   rsp      source  valid & ready     found, mac_out, slot, expired_count
//   cfg      sink    valid & ready     entry_timeout (always ready)
//
// lookup, insert and tick each scan the whole table through one memory read port, one entry a cycle;
// an unused command skips the scan, and insert writes its free slot in a WRITE state after the scan.
// after reset a clearing pass over all ENTRIES runs before req is ready.
// the result sits in an output register, so the next request is taken while it waits;
// a stalled rsp holds the engine only once a second result is finished.
`timescale 1ns / 1ps
module arp_cache_with_aging_unit
  import arpc_pkg::*;
#(
  parameter int ENTRIES = 128
) (
  input logic         clk,
  input logic         rst,
  arpc_req_if.sink    req,
  arpc_rsp_if.source  rsp,
  arpc_cfg_if.sink    cfg
);

  logic [TMO_W-1:0] entry_timeout;
  logic [SEC_W-1:0] now_seconds;
  logic [SEC_W-1:0] now_seconds_next;
  logic             start;
  eng_ctl_t         eng_ctl;
  eng_stat_t        eng_stat;

  assign cfg.ready = 1'b1;
  assign req.ready = eng_stat.ready;
  assign start     = req.valid && req.ready;

  // a tick advances the clock before aging is judged
  assign now_seconds_next = (req.command == CMD_TICK) ? now_seconds + 1'b1 : now_seconds;

  assign eng_ctl.start       = start;
  assign eng_ctl.take        = !rsp.valid || rsp.ready;
  assign eng_ctl.job.cmd     = req.command;
  assign eng_ctl.job.ip      = req.ip_addr;
  assign eng_ctl.job.mac     = req.mac_addr;
  assign eng_ctl.job.now     = now_seconds_next;
  assign eng_ctl.job.timeout = entry_timeout;

  arpc_table #(
    .ENTRIES(ENTRIES)
  ) u_table (
    .clk (clk),
    .rst (rst),
    .ctl (eng_ctl),
    .stat(eng_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_timeout <= TIMEOUT_RESET;
      now_seconds   <= '0;
      rsp.valid     <= 1'b0;
    end else begin
      if (cfg.valid) begin
        entry_timeout <= cfg.entry_timeout;
      end
      if (start) begin
        now_seconds <= now_seconds_next;
      end
      if (eng_stat.done) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (eng_stat.done) begin
      rsp.found         <= eng_stat.res.found;
      rsp.mac_out       <= eng_stat.res.mac;
      rsp.slot          <= eng_stat.res.slot;
      rsp.expired_count <= eng_stat.res.expired;
    end
  end

endmodule

// File: sv/arpc_table.sv
// arpc_table: entry memory and the scan engine that serves one command at a time
`timescale 1ns / 1ps
module arpc_table
  import arpc_pkg::*;
#(
  parameter int ENTRIES = 128
) (
  input  logic      clk,
  input  logic      rst,
  input  eng_ctl_t  ctl,
  output eng_stat_t stat
);

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int WW = $bits(entry_t);
  localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);

  typedef enum logic [2:0] {CLEAR, IDLE, SCAN, WRITE, FINISH} state_t;

  state_t               state;
  job_t                 job;
  logic [AW-1:0]        issue_idx;
  logic                 issue_done;
  logic                 data_vld;
  logic [AW-1:0]        data_idx;
  logic                 hit;
  logic [47:0]          hit_mac;
  logic [AW-1:0]        hit_slot;
  logic                 free_found;
  logic [AW-1:0]        free_slot;
  logic [COUNT_W-1:0]   exp_cnt;

  logic [WW-1:0]        mem [ENTRIES];
  entry_t               rd_word;
  logic                 re;
  logic                 we;
  logic [AW-1:0]        waddr;
  entry_t               wdata;

  logic [SEC_W-1:0]     age;
  logic                 expire_hit;
  logic [AW-1:0]        res_idx;
  logic [AW+SLOT_W-1:0] res_idx_wide;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_word <= mem[issue_idx];
    end
  end

  assign age        = job.now - rd_word.stamp;
  assign expire_hit = rd_word.valid && (age > {1'b0, job.timeout});
  assign re         = (state == SCAN) && !issue_done;

  always_comb begin
    we    = 1'b0;
    waddr = data_idx;
    wdata = rd_word;
    case (state)
      CLEAR: begin
        we    = 1'b1;
        waddr = issue_idx;
        wdata = '0;
      end
      SCAN: begin
        // aged-out entry: write back with valid cleared
        if (data_vld && (job.cmd == CMD_TICK) && expire_hit) begin
          we          = 1'b1;
          wdata.valid = 1'b0;
        end
      end
      WRITE: begin
        we          = free_found;
        waddr       = free_slot;
        wdata.valid = 1'b1;
        wdata.ip    = job.ip;
        wdata.mac   = job.mac;
        wdata.stamp = job.now;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= CLEAR;
      issue_idx  <= '0;
      issue_done <= 1'b0;
      data_vld   <= 1'b0;
      hit        <= 1'b0;
      free_found <= 1'b0;
      exp_cnt    <= '0;
    end else begin
      case (state)
        CLEAR: begin
          issue_idx <= issue_idx + 1'b1;
          if (issue_idx == LAST) begin
            issue_idx <= '0;
            state     <= IDLE;
          end
        end
        IDLE: begin
          if (ctl.start) begin
            job        <= ctl.job;
            hit        <= 1'b0;
            free_found <= 1'b0;
            exp_cnt    <= '0;
            issue_idx  <= '0;
            issue_done <= 1'b0;
            data_vld   <= 1'b0;
            if ((ctl.job.cmd == CMD_LOOKUP) || (ctl.job.cmd == CMD_INSERT) ||
                (ctl.job.cmd == CMD_TICK)) begin
              state <= SCAN;
            end else begin
              state <= FINISH;
            end
          end
        end
        SCAN: begin
          data_vld <= !issue_done;
          data_idx <= issue_idx;
          if (!issue_done) begin
            issue_idx <= issue_idx + 1'b1;
            if (issue_idx == LAST) begin
              issue_done <= 1'b1;
            end
          end
          if (data_vld) begin
            case (job.cmd)
              CMD_LOOKUP: begin
                // later matches override, so the highest index wins
                if (rd_word.valid && (rd_word.ip == job.ip)) begin
                  hit      <= 1'b1;
                  hit_mac  <= rd_word.mac;
                  hit_slot <= data_idx;
                end
              end
              CMD_INSERT: begin
                if (!rd_word.valid && !free_found) begin
                  free_found <= 1'b1;
                  free_slot  <= data_idx;
                end
              end
              CMD_TICK: begin
                if (expire_hit && (exp_cnt != {COUNT_W{1'b1}})) begin
                  exp_cnt <= exp_cnt + 1'b1;
                end
              end
              default: begin
              end
            endcase
          end
          if (issue_done && !data_vld) begin
            state <= (job.cmd == CMD_INSERT) ? WRITE : FINISH;
          end
        end
        WRITE: begin
          state <= FINISH;
        end
        FINISH: begin
          if (ctl.take) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  // slot is reported in its low seven bits
  assign res_idx      = hit ? hit_slot : (free_found ? free_slot : '0);
  assign res_idx_wide = {{SLOT_W{1'b0}}, res_idx};

  assign stat.ready       = (state == IDLE);
  assign stat.done        = (state == FINISH) && ctl.take;
  assign stat.res.found   = hit || free_found;
  assign stat.res.mac     = hit ? hit_mac : 48'd0;
  assign stat.res.slot    = (hit || free_found) ? res_idx_wide[SLOT_W-1:0] : '0;
  assign stat.res.expired = exp_cnt;

endmodule
